// ===== design/ole_pkg.sv =====
// Package for ordered_list_engine: list sizing, op codes, status codes.
// No dependencies.
`default_nettype none
package ole_pkg;
  localparam int DEPTH      = 1024;   // list entries
  localparam int VALUE_BITS = 32;     // signed entry width

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_COUNT  = 3'd3;
  localparam logic [2:0] OP_DEDUP  = 3'd4;
  localparam logic [2:0] OP_RMRANGE = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
endpackage
`default_nettype wire

// ===== design/ordered_list_engine_top.sv =====
// Top level of ordered_list_engine: sequencer around a single list memory.
// Depends on ole_pkg.
//
// Usage:
//  - Input channel in_*: tdata = {upper_bound, value, position, op} packed from bit 0:
//    op[2:0], position[13:3], value[45:14], upper_bound[77:46], zero fill to 80 bits.
//  - Output channel out_*: tdata = answer[10:0], status[12:11], list_length[23:13],
//    zero fill to 24 bits. One result word per input word, in order.
//  - List size and entry width come from ole_pkg (DEPTH, VALUE_BITS).
//  - One operation at a time. The list lives in a memory with a registered read
//    port; the sequencer walks it one entry per read/write step.
//    Insert/delete shift the entries behind the position; find/count/remove-range
//    walk the entries in order. Remove-duplicates runs an inner compare walk over
//    the kept prefix for each entry, one memory read per entry.
//  - Reset clears the entry count and the control state; memory contents are
//    not cleared, since only written entries are ever read.
//  - A finished result waits in the output register; in_tready stays low until
//    it is taken, so a stalled receiver holds the block.
`default_nettype none
module ordered_list_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // op, position, value, upper_bound
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // answer, status, list_length
);
  localparam int DEPTH = ole_pkg::DEPTH;
  localparam int VALUE_BITS = ole_pkg::VALUE_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_EXEC, S_IN_RD2, S_DD_RDK, S_DD_WAITK, S_DD_CMP, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;     // entry_count
  logic [2:0] op_r, op_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic signed [VALUE_BITS-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] j_r, j_nxt, w_r, w_nxt, k_r, k_nxt;
  logic [VALUE_BITS-1:0] cur_r, cur_nxt; // entry j held during dedup
  logic [10:0] ans_r, ans_nxt;
  logic [1:0] st_r, st_nxt;
  logic out_v_r, out_v_nxt;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_r;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic signed [VALUE_BITS-1:0] rsig;
  logic in_rng;
  assign rsig = rdata_r;
  assign in_rng = (rsig >= lo_r) && (rsig <= hi_r);

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata = {11'(cnt_r), st_r, ans_r};

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; op_nxt = op_r; pos_nxt = pos_r;
    lo_nxt = lo_r; hi_nxt = hi_r; j_nxt = j_r; w_nxt = w_r; k_nxt = k_r;
    cur_nxt = cur_r; ans_nxt = ans_r; st_nxt = st_r; out_v_nxt = out_v_r;
    we = 1'b0; waddr = j_r[AW-1:0]; raddr = j_r[AW-1:0]; wdata = rdata_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        op_nxt = in_tdata[2:0];
        pos_nxt = in_tdata[13:3];
        lo_nxt = VALUE_BITS'(in_tdata[45:14]);
        hi_nxt = VALUE_BITS'(in_tdata[77:46]);
        ans_nxt = '0; st_nxt = ole_pkg::ST_DONE;
        j_nxt = '0; w_nxt = '0; k_nxt = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_OUT;
        priority case (op_r)
          ole_pkg::OP_INSERT:
            if (cnt_r >= CW'(DEPTH)) st_nxt = ole_pkg::ST_FULL;
            else if (pos_r == 0 || 32'(pos_r) > 32'(cnt_r) + 1) st_nxt = ole_pkg::ST_BADPOS;
            else begin j_nxt = cnt_r; state_nxt = S_EXEC; end
          ole_pkg::OP_DELETE:
            if (pos_r == 0 || 32'(pos_r) > 32'(cnt_r)) st_nxt = ole_pkg::ST_BADPOS;
            else begin j_nxt = CW'(pos_r - 11'd1); state_nxt = S_EXEC; end
          ole_pkg::OP_FIND, ole_pkg::OP_COUNT, ole_pkg::OP_RMRANGE, ole_pkg::OP_DEDUP:
            state_nxt = S_EXEC;
          default: ;
        endcase
      end
      S_EXEC: begin
        // dispatch step: issue a read or finish
        priority case (op_r)
          ole_pkg::OP_INSERT:
            if (j_r > CW'(pos_r - 11'd1)) begin
              raddr = AW'(j_r - CW'(1)); state_nxt = S_WAIT;
            end else begin
              we = 1'b1; waddr = AW'(j_r); wdata = lo_r;
              cnt_nxt = cnt_r + CW'(1); state_nxt = S_OUT;
            end
          ole_pkg::OP_DELETE:
            if (j_r + CW'(1) < cnt_r) begin
              raddr = AW'(j_r + CW'(1)); state_nxt = S_WAIT;
            end else begin cnt_nxt = cnt_r - CW'(1); state_nxt = S_OUT; end
          default:
            if (j_r < cnt_r) begin raddr = AW'(j_r); state_nxt = S_WAIT; end
            else begin
              if (op_r == ole_pkg::OP_DEDUP || op_r == ole_pkg::OP_RMRANGE) cnt_nxt = w_r;
              state_nxt = S_OUT;
            end
        endcase
      end
      S_WAIT: begin
        state_nxt = S_EXEC;
        priority case (op_r)
          ole_pkg::OP_INSERT: begin
            we = 1'b1; waddr = AW'(j_r); j_nxt = j_r - CW'(1);
          end
          ole_pkg::OP_DELETE: begin
            we = 1'b1; waddr = AW'(j_r); j_nxt = j_r + CW'(1);
          end
          ole_pkg::OP_FIND:
            if (rsig == lo_r) begin
              ans_nxt = 11'(j_r + CW'(1)); state_nxt = S_OUT;
            end else j_nxt = j_r + CW'(1);
          ole_pkg::OP_COUNT: begin
            if (in_rng) ans_nxt = ans_r + 11'd1;
            j_nxt = j_r + CW'(1);
          end
          ole_pkg::OP_RMRANGE: begin
            if (!in_rng) begin
              we = 1'b1; waddr = AW'(w_r); w_nxt = w_r + CW'(1);
            end
            j_nxt = j_r + CW'(1);
          end
          default: begin // dedup: hold entry j, scan kept prefix
            cur_nxt = rdata_r; k_nxt = '0; state_nxt = S_DD_RDK;
          end
        endcase
      end
      S_DD_RDK:
        if (k_r < w_r) begin
          raddr = AW'(k_r); state_nxt = S_DD_CMP;
        end else begin
          we = 1'b1; waddr = AW'(w_r); wdata = cur_r;
          w_nxt = w_r + CW'(1); j_nxt = j_r + CW'(1); state_nxt = S_EXEC;
        end
      S_DD_CMP:
        if (rdata_r == cur_r) begin
          j_nxt = j_r + CW'(1); state_nxt = S_EXEC;
        end else begin
          k_nxt = k_r + CW'(1); state_nxt = S_DD_RDK;
        end
      S_OUT: begin
        out_v_nxt = 1'b1;
        if (out_v_r && out_tready) begin
          out_v_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; out_v_r <= out_v_nxt;
    end
    op_r <= op_nxt; pos_r <= pos_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
    j_r <= j_nxt; w_r <= w_nxt; k_r <= k_nxt; cur_r <= cur_nxt;
    ans_r <= ans_nxt; st_r <= st_nxt;
  end

  // result only offered from the output state
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == S_OUT) else $error("out valid outside S_OUT");
  // count never exceeds depth
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("entry count overflow");
  // no new word taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("accept while result pending");
endmodule
`default_nettype wire

// ===== tb/ordered_list_engine_top_tb.sv =====
// Testbench for ordered_list_engine_top: directed and random list operations over the
// stream ports, checked word by word against a predictor in a scoreboard class.
// Depends on ole_pkg and ordered_list_engine_top.
`timescale 1ns / 1ps

module ordered_list_engine_top_tb;

  localparam int LIST_DEPTH = 1024;
  localparam int RANDOM_OPS = 557;

  // Keeps its own copy of the list, predicts one result per accepted word and
  // checks result words in order.
  class list_scoreboard;
    logic signed [31:0] entries [LIST_DEPTH];
    int unsigned        held;
    logic [23:0]        pending [$];
    int                 errors;
    int                 checked;

    function new();
      held = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_input(logic [2:0] op, logic [10:0] pos,
                             logic signed [31:0] val, logic signed [31:0] ub);
      logic [10:0] answer;
      logic [1:0]  status;
      int unsigned kept;
      bit          seen;
      answer = '0;
      status = ole_pkg::ST_DONE;
      case (op)
        ole_pkg::OP_INSERT: begin
          if (held >= LIST_DEPTH) begin
            status = ole_pkg::ST_FULL;
          end else if (pos < 1 || pos > held + 1) begin
            status = ole_pkg::ST_BADPOS;
          end else begin
            for (int j = held; j > pos - 1; j--) entries[j] = entries[j-1];
            entries[pos-1] = val;
            held++;
          end
        end
        ole_pkg::OP_DELETE: begin
          if (pos < 1 || pos > held) begin
            status = ole_pkg::ST_BADPOS;
          end else begin
            for (int j = pos - 1; j + 1 < held; j++) entries[j] = entries[j+1];
            held--;
          end
        end
        ole_pkg::OP_FIND: begin
          for (int j = 0; j < held; j++) begin
            if (entries[j] == val) begin
              answer = j + 1;
              break;
            end
          end
        end
        ole_pkg::OP_COUNT: begin
          for (int j = 0; j < held; j++)
            if (entries[j] >= val && entries[j] <= ub) answer++;
        end
        ole_pkg::OP_DEDUP: begin
          kept = 0;
          for (int j = 0; j < held; j++) begin
            seen = 0;
            for (int k = 0; k < kept; k++)
              if (entries[k] == entries[j]) seen = 1;
            if (!seen) begin
              entries[kept] = entries[j];
              kept++;
            end
          end
          held = kept;
        end
        ole_pkg::OP_RMRANGE: begin
          kept = 0;
          for (int j = 0; j < held; j++) begin
            if (entries[j] < val || entries[j] > ub) begin
              entries[kept] = entries[j];
              kept++;
            end
          end
          held = kept;
        end
        default: ;
      endcase
      pending.push_back({held[10:0], status, answer});
    endfunction

    function void check_result(logic [23:0] word);
      logic [23:0] exp_word;
      if (pending.size() == 0) begin
        $error("result word %h with nothing expected", word);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      checked++;
      if (word[10:0] !== exp_word[10:0]) begin
        $error("answer: expected %0d, got %0d", exp_word[10:0], word[10:0]);
        errors++;
      end
      if (word[12:11] !== exp_word[12:11]) begin
        $error("status: expected %0d, got %0d", exp_word[12:11], word[12:11]);
        errors++;
      end
      if (word[23:13] !== exp_word[23:13]) begin
        $error("list_length: expected %0d, got %0d", exp_word[23:13], word[23:13]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // op, position, value, upper_bound
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;       // answer, status, list_length

  list_scoreboard sb = new();

  int burst_left = 0;
  int words_sent = 0;
  int full_hits = 0;
  int badpos_hits = 0;

  always #1 clk = ~clk;

  ordered_list_engine_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Receiver: switches between always-ready, coin-flip and long-stall modes.
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= $urandom_range(0, 1);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tdata[12:11] == ole_pkg::ST_FULL) full_hits++;
      if (out_tdata[12:11] == ole_pkg::ST_BADPOS) badpos_hits++;
      sb.check_result(out_tdata);
    end
  end

  // Send one word; valid stays high inside a burst and, unless the random gap
  // between bursts is zero, drops for that gap.
  task automatic send_op(logic [2:0] op, logic [10:0] pos,
                         logic signed [31:0] val, logic signed [31:0] ub);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (in_tvalid && gap > 0) in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, ub, val, pos, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, pos, val, ub);
    words_sent++;
    burst_left--;
  endtask

  // Value pool: small set so finds and duplicates hit, with extremes and noise.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3: return $urandom;
      default: return $signed(32'($urandom_range(0, 24))) - 12;
    endcase
  endfunction

  task automatic random_op();
    logic [2:0]         op;
    logic [10:0]        pos;
    logic signed [31:0] a, b;
    int                 r;
    r = $urandom_range(0, 99);
    // Grow the list while short, trim it while long; dedup stays cheap.
    if (r < (sb.held < 40 ? 45 : 20)) op = ole_pkg::OP_INSERT;
    else if (r < 62) op = ole_pkg::OP_DELETE;
    else if (r < 74) op = ole_pkg::OP_FIND;
    else if (r < 84) op = ole_pkg::OP_COUNT;
    else if (r < 90) op = ole_pkg::OP_DEDUP;
    else if (r < 97) op = ole_pkg::OP_RMRANGE;
    else op = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 9) == 0) pos = $urandom;
    else pos = $urandom_range(1, sb.held + 1);
    a = pick_value();
    b = pick_value();
    // Mostly ordered bounds; a reversed range now and then.
    if (a > b && $urandom_range(0, 4) != 0) begin
      send_op(op, pos, b, a);
    end else begin
      send_op(op, pos, a, b);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list corners, bad positions, extremes, unused op codes.
    send_op(ole_pkg::OP_DELETE, 11'd1, 0, 0);
    send_op(ole_pkg::OP_FIND, 11'd0, 5, 0);
    send_op(ole_pkg::OP_COUNT, 11'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(ole_pkg::OP_DEDUP, 11'd0, 0, 0);
    send_op(ole_pkg::OP_RMRANGE, 11'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(3'd6, 11'h7ff, -1, -1);
    send_op(3'd7, 11'd1, 1, 1);
    send_op(ole_pkg::OP_INSERT, 11'd0, 7, 0);
    send_op(ole_pkg::OP_INSERT, 11'd2, 7, 0);
    send_op(ole_pkg::OP_INSERT, 11'd1, 32'sh8000_0000, 0);
    send_op(ole_pkg::OP_INSERT, 11'd2, 32'sh7fff_ffff, 0);
    send_op(ole_pkg::OP_INSERT, 11'd2, -1, 0);
    send_op(ole_pkg::OP_INSERT, 11'd1, -1, 0);
    send_op(ole_pkg::OP_FIND, 11'd0, -1, 0);
    send_op(ole_pkg::OP_FIND, 11'd0, 32'sh7fff_ffff, 0);
    send_op(ole_pkg::OP_COUNT, 11'd0, 5, -5);
    send_op(ole_pkg::OP_COUNT, 11'd0, 32'sh8000_0000, 32'sh7fff_ffff);
    send_op(ole_pkg::OP_DELETE, 11'h7ff, 0, 0);
    send_op(ole_pkg::OP_DELETE, 11'd5, 0, 0);
    send_op(ole_pkg::OP_DEDUP, 11'd0, 0, 0);
    send_op(ole_pkg::OP_RMRANGE, 11'd0, 5, -5);
    send_op(ole_pkg::OP_RMRANGE, 11'd0, -1, 0);
    send_op(ole_pkg::OP_DELETE, 11'd1, 0, 0);

    for (int i = 0; i < RANDOM_OPS; i++) random_op();

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("sent %0d words, checked %0d results (%0d full, %0d bad position)",
             words_sent, sb.checked, full_hits, badpos_hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ordered_list_engine_top_tb: clean");
    end else begin
      $display("ordered_list_engine_top_tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40ms;
    $display("timeout waiting for the block");
    $display("ordered_list_engine_top_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ole_pkg.sv
design/ordered_list_engine_top.sv
tb/ordered_list_engine_top_tb.sv
